/* rtl/prtz_pkg.sv */
package prtz_pkg;

	// fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int CORDIC_STAGES_DEF = 20;
	localparam int COORD_W = 32;
	localparam int ANG_W = 26;

	// angle reduction, degrees with FRAC_BITS fraction bits
	localparam int RED_W = 28;
	localparam int U_W = 25;
	localparam int MAG_W = 23;
	localparam int QUARTER_TURN = 90 << FRAC_BITS;
	localparam int HALF_TURN = 180 << FRAC_BITS;
	localparam int FULL_TURN = 360 << FRAC_BITS;

	// degrees to radians (pi/180 * 2^32) and Q30 conversion
	localparam int DEG2RAD_W = 27;
	localparam logic [DEG2RAD_W-1:0] DEG2RAD_Q32 = 27'd74961321;
	localparam int PROD_W = MAG_W + DEG2RAD_W;
	localparam int RAD_SHIFT = FRAC_BITS + 2;

	// cordic datapath
	localparam int XY_W = 32;
	localparam int Z_W = 33;
	localparam int ATAN_W = 31;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam int Q30_SHIFT = 30;

	// coordinates that travel alongside the angle
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic signed [COORD_W-1:0] dx;
		logic signed [COORD_W-1:0] dy;
		logic signed [COORD_W-1:0] dz;
	} side_t;

	// per-stage control between pipeline parts
	typedef struct packed {
		logic valid;
		logic flip;
	} ctl_t;

	// atan(2^-i) in Q30
	function automatic logic [ATAN_W-1:0] atan_q30(input int idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			0: v = 31'd843314856;
			1: v = 31'd497837829;
			2: v = 31'd263043836;
			3: v = 31'd133525158;
			4: v = 31'd67021686;
			5: v = 31'd33543515;
			6: v = 31'd16775850;
			7: v = 31'd8388437;
			8: v = 31'd4194282;
			9: v = 31'd2097149;
			10: v = 31'd1048575;
			11: v = 31'd524287;
			12: v = 31'd262143;
			13: v = 31'd131071;
			14: v = 31'd65535;
			15: v = 31'd32767;
			16: v = 31'd16383;
			17: v = 31'd8191;
			18: v = 31'd4095;
			19: v = 31'd2047;
			20: v = 31'd1023;
			21: v = 31'd511;
			22: v = 31'd255;
			23: v = 31'd127;
			24: v = 31'd63;
			25: v = 31'd31;
			26: v = 31'd15;
			27: v = 31'd7;
			28: v = 31'd3;
			29: v = 31'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/prtz_angle.sv */
module prtz_angle (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic src_valid,
	input  logic signed [prtz_pkg::ANG_W-1:0] src_angle,
	input  prtz_pkg::side_t src_side,
	output prtz_pkg::ctl_t dst_ctl,
	output logic signed [prtz_pkg::Z_W-1:0] dst_z,
	output prtz_pkg::side_t dst_side
);
	import prtz_pkg::*;

	localparam logic signed [RED_W-1:0] FULL_R = RED_W'(FULL_TURN);
	localparam logic signed [RED_W-1:0] FULL2_R = RED_W'(2 * FULL_TURN);
	localparam logic signed [RED_W-1:0] HALF_R = RED_W'(HALF_TURN);
	localparam logic signed [RED_W-1:0] QUARTER_R = RED_W'(QUARTER_TURN);
	localparam logic signed [RED_W-1:0] THREE_Q_R = RED_W'(3 * QUARTER_TURN);
	localparam logic [PROD_W-1:0] RAD_ROUND = PROD_W'(1) << (FRAC_BITS + 1);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic flip_s2, flip_s3, flip_s4;
	logic neg_s2, neg_s3;
	logic [U_W-1:0] u_s1;
	logic [MAG_W-1:0] mag_s2;
	logic [PROD_W-1:0] prod_s3;
	logic signed [Z_W-1:0] z_s4;
	side_t side_s1, side_s2, side_s3, side_s4;

	logic signed [RED_W-1:0] a_ext;
	logic signed [RED_W-1:0] u_next;
	logic signed [RED_W-1:0] u_ext;
	logic signed [RED_W-1:0] r_next;
	logic flip_next;
	logic [PROD_W-1:0] rad_sum;
	logic [Z_W-1:0] t_ext;

	// floor modulo one full turn, input is within two turns either way
	assign a_ext = RED_W'(src_angle);
	always_comb begin
		priority if (a_ext >= FULL_R) begin
			u_next = a_ext - FULL_R;
		end else if (a_ext >= 0) begin
			u_next = a_ext;
		end else if (a_ext + FULL_R >= 0) begin
			u_next = a_ext + FULL_R;
		end else begin
			u_next = a_ext + FULL2_R;
		end
	end

	// fold into plus or minus a quarter turn, note the sign flip
	assign u_ext = RED_W'(u_s1);
	always_comb begin
		priority if (u_ext <= QUARTER_R) begin
			r_next = u_ext;
			flip_next = 1'b0;
		end else if (u_ext < THREE_Q_R) begin
			r_next = u_ext - HALF_R;
			flip_next = 1'b1;
		end else begin
			r_next = u_ext - FULL_R;
			flip_next = 1'b0;
		end
	end

	// round half up on the magnitude, then restore sign
	assign rad_sum = prod_s3 + RAD_ROUND;
	assign t_ext = Z_W'(rad_sum[PROD_W-1:RAD_SHIFT]);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_next[U_W-1:0];
			side_s1 <= src_side;

			neg_s2 <= r_next[RED_W-1];
			mag_s2 <= r_next[RED_W-1] ? MAG_W'(-r_next) : MAG_W'(r_next);
			flip_s2 <= flip_next;
			side_s2 <= side_s1;

			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(DEG2RAD_Q32);
			neg_s3 <= neg_s2;
			flip_s3 <= flip_s2;
			side_s3 <= side_s2;

			z_s4 <= neg_s3 ? -$signed(t_ext) : $signed(t_ext);
			flip_s4 <= flip_s3;
			side_s4 <= side_s3;
		end
	end

	assign dst_ctl.valid = valid_s4;
	assign dst_ctl.flip = flip_s4;
	assign dst_z = z_s4;
	assign dst_side = side_s4;

	// reduced angle stays inside one turn
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (RED_W'(u_s1) < FULL_R))
		else $error("reduced angle outside one turn");

	// folded magnitude never exceeds a quarter turn
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (RED_W'(mag_s2) <= QUARTER_R))
		else $error("folded angle beyond a quarter turn");

endmodule

/* rtl/prtz_cell.sv */
module prtz_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  prtz_pkg::ctl_t prev_ctl,
	input  logic signed [prtz_pkg::XY_W-1:0] prev_x,
	input  logic signed [prtz_pkg::XY_W-1:0] prev_y,
	input  logic signed [prtz_pkg::Z_W-1:0] prev_z,
	input  prtz_pkg::side_t prev_side,
	output prtz_pkg::ctl_t next_ctl,
	output logic signed [prtz_pkg::XY_W-1:0] next_x,
	output logic signed [prtz_pkg::XY_W-1:0] next_y,
	output logic signed [prtz_pkg::Z_W-1:0] next_z,
	output prtz_pkg::side_t next_side
);
	import prtz_pkg::*;

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] step;
	logic valid_q;
	logic flip_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;
	side_t side_q;

	// shifted terms and this stage's arctangent
	assign xs = prev_x >>> STAGE;
	assign ys = prev_y >>> STAGE;
	assign step = Z_W'(atan_q30(STAGE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_ctl.valid;
		end
	end

	// one micro-rotation, direction from the residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (prev_z >= 0) begin
				x_q <= prev_x - ys;
				y_q <= prev_y + xs;
				z_q <= prev_z - step;
			end else begin
				x_q <= prev_x + ys;
				y_q <= prev_y - xs;
				z_q <= prev_z + step;
			end
			flip_q <= prev_ctl.flip;
			side_q <= prev_side;
		end
	end

	assign next_ctl.valid = valid_q;
	assign next_ctl.flip = flip_q;
	assign next_x = x_q;
	assign next_y = y_q;
	assign next_z = z_q;
	assign next_side = side_q;

endmodule

/* rtl/prtz_combine.sv */
module prtz_combine (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  prtz_pkg::ctl_t src_ctl,
	input  logic signed [prtz_pkg::XY_W-1:0] src_cos,
	input  logic signed [prtz_pkg::XY_W-1:0] src_sin,
	input  prtz_pkg::side_t src_side,
	output logic dst_valid,
	output logic signed [prtz_pkg::COORD_W-1:0] dst_x,
	output logic signed [prtz_pkg::COORD_W-1:0] dst_y,
	output logic signed [prtz_pkg::COORD_W-1:0] dst_z,
	output logic dst_overflow
);
	import prtz_pkg::*;

	localparam int P_W = COORD_W + XY_W;
	localparam int S_W = P_W + 1;
	localparam int R_W = S_W - Q30_SHIFT;
	localparam int F_W = R_W + 1;
	localparam int ZS_W = COORD_W + 1;
	localparam logic signed [S_W-1:0] Q30_ROUND = S_W'(1) <<< (Q30_SHIFT - 1);
	localparam logic signed [XY_W-1:0] TRIG_BOUND = XY_W'((1 << Q30_SHIFT) + (1 << 24));
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [XY_W-1:0] cos_s1, sin_s1;
	side_t side_s1;
	logic signed [P_W-1:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [COORD_W-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [ZS_W-1:0] zs_s2, zs_s3;
	logic signed [R_W-1:0] rx_s3, ry_s3;
	logic signed [COORD_W-1:0] x_s4, y_s4, z_s4;
	logic ov_s4;

	logic signed [S_W-1:0] sum_x, sum_y;
	logic signed [F_W-1:0] fx, fy;
	logic sat_x, sat_y, sat_z;
	logic signed [COORD_W-1:0] ox, oy, oz;

	// rounded Q30 products back to coordinate scale
	assign sum_x = S_W'(pxc_s2) - S_W'(pys_s2) + Q30_ROUND;
	assign sum_y = S_W'(pxs_s2) + S_W'(pyc_s2) + Q30_ROUND;

	// add the shift and saturate each coordinate
	assign fx = F_W'(rx_s3) + F_W'(dx_s3);
	assign fy = F_W'(ry_s3) + F_W'(dy_s3);
	assign sat_x = (fx[F_W-1:COORD_W-1] != {(F_W-COORD_W+1){fx[F_W-1]}});
	assign sat_y = (fy[F_W-1:COORD_W-1] != {(F_W-COORD_W+1){fy[F_W-1]}});
	assign sat_z = (zs_s3[ZS_W-1] != zs_s3[ZS_W-2]);
	assign ox = sat_x ? (fx[F_W-1] ? C_MIN : C_MAX) : fx[COORD_W-1:0];
	assign oy = sat_y ? (fy[F_W-1] ? C_MIN : C_MAX) : fy[COORD_W-1:0];
	assign oz = sat_z ? (zs_s3[ZS_W-1] ? C_MIN : C_MAX) : zs_s3[COORD_W-1:0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_ctl.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= src_ctl.flip ? -src_cos : src_cos;
			sin_s1 <= src_ctl.flip ? -src_sin : src_sin;
			side_s1 <= src_side;

			pxc_s2 <= P_W'(side_s1.px) * P_W'(cos_s1);
			pys_s2 <= P_W'(side_s1.py) * P_W'(sin_s1);
			pxs_s2 <= P_W'(side_s1.px) * P_W'(sin_s1);
			pyc_s2 <= P_W'(side_s1.py) * P_W'(cos_s1);
			dx_s2 <= side_s1.dx;
			dy_s2 <= side_s1.dy;
			zs_s2 <= ZS_W'(side_s1.pz) + ZS_W'(side_s1.dz);

			rx_s3 <= sum_x[S_W-1:Q30_SHIFT];
			ry_s3 <= sum_y[S_W-1:Q30_SHIFT];
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			zs_s3 <= zs_s2;

			x_s4 <= ox;
			y_s4 <= oy;
			z_s4 <= oz;
			ov_s4 <= sat_x | sat_y | sat_z;
		end
	end

	assign dst_valid = valid_s4;
	assign dst_x = x_s4;
	assign dst_y = y_s4;
	assign dst_z = z_s4;
	assign dst_overflow = ov_s4;

	// cosine and sine stay close to the unit range
	a_trig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cos_s1 <= TRIG_BOUND && cos_s1 >= -TRIG_BOUND &&
			sin_s1 <= TRIG_BOUND && sin_s1 >= -TRIG_BOUND))
		else $error("cordic output outside unit range");

	// a flagged item carries at least one saturated coordinate
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && ov_s4) |-> (x_s4 == C_MAX || x_s4 == C_MIN ||
			y_s4 == C_MAX || y_s4 == C_MIN || z_s4 == C_MAX || z_s4 == C_MIN))
		else $error("overflow flag without saturated coordinate");

endmodule

/* rtl/point_rotate_z_translate.sv */
// Rotates a 3D point about the Z axis by a per-item angle in degrees, then
// adds a per-item translation. All coordinates are signed with 16 fraction bits.
//
// Input channel: in_valid / in_stall with in_x, in_y, in_z, angle_deg and
// shift_x, shift_y, shift_z. Output channel: out_valid / out_stall with
// out_x, out_y, out_z and overflow, which is set when any coordinate saturated.
//
// Stages in order: angle reduction and conversion to radians, the CORDIC
// cells (20 with the default CORDIC_STAGES), then sign fold, products,
// rounding and the saturating add. Throughput is one item per cycle while
// no result waits on out_stall; every stage is a register stage.
//
// The whole pipeline advances together. While out_valid is high and
// out_stall is asserted, every stage holds and in_stall is raised in the
// same cycle, so the waiting result stays on the output unchanged.
//
// Reset clears the valid bit of every stage; the block is ready for an item
// as soon as reset is released.
module point_rotate_z_translate #(
	parameter int CORDIC_STAGES = prtz_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [prtz_pkg::COORD_W-1:0] in_x,
	input  logic signed [prtz_pkg::COORD_W-1:0] in_y,
	input  logic signed [prtz_pkg::COORD_W-1:0] in_z,
	input  logic signed [prtz_pkg::ANG_W-1:0] angle_deg,
	input  logic signed [prtz_pkg::COORD_W-1:0] shift_x,
	input  logic signed [prtz_pkg::COORD_W-1:0] shift_y,
	input  logic signed [prtz_pkg::COORD_W-1:0] shift_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [prtz_pkg::COORD_W-1:0] out_x,
	output logic signed [prtz_pkg::COORD_W-1:0] out_y,
	output logic signed [prtz_pkg::COORD_W-1:0] out_z,
	output logic overflow
);
	import prtz_pkg::*;

	logic en;
	side_t in_side;
	ctl_t chain_ctl [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] chain_x [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] chain_y [CORDIC_STAGES+1];
	logic signed [Z_W-1:0] chain_z [CORDIC_STAGES+1];
	side_t chain_side [CORDIC_STAGES+1];

	// global advance: hold everything while a result waits on a stall
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	assign in_side.px = in_x;
	assign in_side.py = in_y;
	assign in_side.pz = in_z;
	assign in_side.dx = shift_x;
	assign in_side.dy = shift_y;
	assign in_side.dz = shift_z;

	// angle reduction and conversion to a Q30 radian angle
	prtz_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (in_valid),
		.src_angle (angle_deg),
		.src_side  (in_side),
		.dst_ctl   (chain_ctl[0]),
		.dst_z     (chain_z[0]),
		.dst_side  (chain_side[0])
	);

	// cordic starts from the gain-compensated unit vector
	assign chain_x[0] = CORDIC_GAIN_Q30;
	assign chain_y[0] = '0;

	// row of cordic cells, one micro-rotation each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		prtz_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.prev_ctl  (chain_ctl[i]),
			.prev_x    (chain_x[i]),
			.prev_y    (chain_y[i]),
			.prev_z    (chain_z[i]),
			.prev_side (chain_side[i]),
			.next_ctl  (chain_ctl[i+1]),
			.next_x    (chain_x[i+1]),
			.next_y    (chain_y[i+1]),
			.next_z    (chain_z[i+1]),
			.next_side (chain_side[i+1])
		);
	end

	// rotation products, rounding, translation and saturation
	prtz_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.src_ctl      (chain_ctl[CORDIC_STAGES]),
		.src_cos      (chain_x[CORDIC_STAGES]),
		.src_sin      (chain_y[CORDIC_STAGES]),
		.src_side     (chain_side[CORDIC_STAGES]),
		.dst_valid    (out_valid),
		.dst_x        (out_x),
		.dst_y        (out_y),
		.dst_z        (out_z),
		.dst_overflow (overflow)
	);

endmodule
